// File: rtl/tqps_pkg.sv
// Package for the two-queue probabilistic scheduler.
// Holds widths, reset values, register indexes, codes and the
// controller/datapath interface structs. No dependencies.
package tqps_pkg;

  // default sizes for the top-level parameters
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ID_BITS     = 8;

  // fixed field widths
  localparam int TIME_W   = 16;
  localparam int SHARE_W  = 7;
  localparam int LEAVE_W  = 2;
  localparam int ROUTE_W  = 3;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_SHARE = 1'd1;

  // configuration reset values
  localparam logic [TIME_W-1:0]  TIME_LIMIT_RESET = 16'd100;
  localparam logic [SHARE_W-1:0] HIGH_SHARE_RESET = 7'd80;

  // leave state codes
  localparam logic [LEAVE_W-1:0] LEAVE_READY    = 2'd0;
  localparam logic [LEAVE_W-1:0] LEAVE_BLOCKED  = 2'd1;
  localparam logic [LEAVE_W-1:0] LEAVE_FINISHED = 2'd2;

  // routing report codes
  localparam logic [ROUTE_W-1:0] ROUTE_NONE     = 3'd0;
  localparam logic [ROUTE_W-1:0] ROUTE_HIGH     = 3'd1;
  localparam logic [ROUTE_W-1:0] ROUTE_LOW      = 3'd2;
  localparam logic [ROUTE_W-1:0] ROUTE_BLOCKED  = 3'd3;
  localparam logic [ROUTE_W-1:0] ROUTE_FINISHED = 3'd4;
  localparam logic [ROUTE_W-1:0] ROUTE_ERROR    = 3'd5;

  // pick queue codes
  localparam logic QUEUE_HIGH = 1'b0;
  localparam logic QUEUE_LOW  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;     // input transfer: latch the item
    logic push;     // route and enqueue
    logic pick;     // choose a queue, start the read, pop
    logic capture;  // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_full; // output register holds an untaken result
  } status_t;

endpackage

// File: rtl/tqps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tqps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/tqps_ctrl.sv
// Sequencing controller for the scheduler: accept, push, pick, capture.
// Depends on tqps_pkg for the command and status structs.
module tqps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              m_tready,
  input  tqps_pkg::status_t status,
  output tqps_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PUSH = 4'b0010,
    ST_PICK = 4'b0100,
    ST_CAPT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   capt_ok;

  // the output register is free, or is being emptied this cycle
  assign capt_ok  = !status.out_full || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push   = 1'b1;
        state_next = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick   = 1'b1;
        state_next = ST_CAPT;
      end
      ST_CAPT: begin
        if (capt_ok) begin
          cmd.capture = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/tqps_datapath.sv
// Datapath of the scheduler: config registers, item latch, two id FIFOs
// (pointers here, storage in tqps_ram), pick logic and output register.
// Depends on tqps_pkg and tqps_ram.
module tqps_datapath #(
  parameter int QUEUE_DEPTH = tqps_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = tqps_pkg::DEF_ID_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tqps_pkg::cmd_t                   cmd,
  output tqps_pkg::status_t                status,
  // configuration writes
  input  logic                             cfg_wr_en,
  input  logic [tqps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tqps_pkg::CFG_W-1:0]       cfg_data,
  // input item fields
  input  logic                             action,
  input  logic [ID_BITS-1:0]               proc_id,
  input  logic [tqps_pkg::LEAVE_W-1:0]     leave_state,
  input  logic [tqps_pkg::TIME_W-1:0]      time_left,
  input  logic [tqps_pkg::SHARE_W-1:0]     random_draw,
  // result
  input  logic                             m_tready,
  output logic                             out_valid,
  output logic                             pick_valid,
  output logic [ID_BITS-1:0]               pick_id,
  output logic                             pick_queue,
  output logic [tqps_pkg::ROUTE_W-1:0]     routed_to,
  output logic                             overflow
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int PROD_W = tqps_pkg::TIME_W + 3;

  // configuration
  logic [tqps_pkg::TIME_W-1:0]  time_limit;
  logic [tqps_pkg::SHARE_W-1:0] high_share;

  // latched item
  logic                         in_action;
  logic [ID_BITS-1:0]           in_id;
  logic [tqps_pkg::LEAVE_W-1:0] in_leave;
  logic [tqps_pkg::TIME_W-1:0]  in_time;
  logic [tqps_pkg::SHARE_W-1:0] in_draw;

  // queue pointers
  logic [PTR_W-1:0] high_head, low_head;
  logic [CNT_W-1:0] high_count, low_count;

  // per-item results
  logic [tqps_pkg::ROUTE_W-1:0] route;
  logic                         ovf;
  logic                         sel_valid, sel_queue;

  // push side
  logic [PROD_W-1:0] time_x5;
  logic              is_short, is_ready, high_full, low_full;
  logic              high_wr, low_wr;
  logic [SUM_W-1:0]  high_sum, low_sum;
  logic [PTR_W-1:0]  high_slot, low_slot;
  logic [tqps_pkg::ROUTE_W-1:0] route_next;
  logic              ovf_next;

  // pick side
  logic              high_avail, low_avail, take_high, take_low;
  logic [ID_BITS-1:0] high_rdata, low_rdata;

  // 5 * time_left <= time_limit, short-job test
  assign time_x5  = {1'b0, in_time, 2'b00} + {3'b000, in_time};
  assign is_short = time_x5 <= {3'b000, time_limit};
  assign is_ready = in_action && (in_leave == tqps_pkg::LEAVE_READY);

  assign high_full = (high_count == CNT_W'(QUEUE_DEPTH));
  assign low_full  = (low_count == CNT_W'(QUEUE_DEPTH));
  assign high_wr   = cmd.push && is_ready && is_short && !high_full;
  assign low_wr    = cmd.push && is_ready && !is_short && !low_full;

  // tail slot = (head + count) mod depth; the sum stays below twice the depth
  assign high_sum  = SUM_W'(high_head) + SUM_W'(high_count);
  assign low_sum   = SUM_W'(low_head) + SUM_W'(low_count);
  assign high_slot = (high_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     PTR_W'(high_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(high_sum);
  assign low_slot  = (low_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     PTR_W'(low_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(low_sum);

  always_comb begin
    route_next = tqps_pkg::ROUTE_NONE;
    ovf_next   = 1'b0;
    if (in_action) begin
      case (in_leave)
        tqps_pkg::LEAVE_READY: begin
          route_next = is_short ? tqps_pkg::ROUTE_HIGH : tqps_pkg::ROUTE_LOW;
          ovf_next   = is_short ? high_full : low_full;
        end
        tqps_pkg::LEAVE_BLOCKED:  route_next = tqps_pkg::ROUTE_BLOCKED;
        tqps_pkg::LEAVE_FINISHED: route_next = tqps_pkg::ROUTE_FINISHED;
        default:                  route_next = tqps_pkg::ROUTE_ERROR;
      endcase
    end
  end

  // pick order: high on a winning draw, else low, else high as fallback
  assign high_avail = (high_count != '0);
  assign low_avail  = (low_count != '0);
  assign take_high  = (in_draw < high_share && high_avail) || (!low_avail && high_avail);
  assign take_low   = !take_high && low_avail;

  tqps_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_high_ram (
    .clk     (clk),
    .wr_en   (high_wr),
    .wr_addr (high_slot),
    .wr_data (in_id),
    .rd_en   (cmd.pick && take_high),
    .rd_addr (high_head),
    .rd_data (high_rdata)
  );

  tqps_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_low_ram (
    .clk     (clk),
    .wr_en   (low_wr),
    .wr_addr (low_slot),
    .wr_data (in_id),
    .rd_en   (cmd.pick && take_low),
    .rd_addr (low_head),
    .rd_data (low_rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_limit <= tqps_pkg::TIME_LIMIT_RESET;
      high_share <= tqps_pkg::HIGH_SHARE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tqps_pkg::REG_TIME_LIMIT: time_limit <= cfg_data;
        tqps_pkg::REG_HIGH_SHARE: high_share <= cfg_data[tqps_pkg::SHARE_W-1:0];
        default: ;
      endcase
    end
  end

  // item latch and per-item payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_action <= action;
      in_id     <= proc_id;
      in_leave  <= leave_state;
      in_time   <= time_left;
      in_draw   <= random_draw;
    end
    if (cmd.push) begin
      route <= route_next;
      ovf   <= ovf_next;
    end
    if (cmd.pick) begin
      sel_valid <= take_high || take_low;
      sel_queue <= take_low ? tqps_pkg::QUEUE_LOW : tqps_pkg::QUEUE_HIGH;
    end
    if (cmd.capture) begin
      pick_valid <= sel_valid;
      pick_queue <= sel_valid ? sel_queue : tqps_pkg::QUEUE_HIGH;
      pick_id    <= !sel_valid ? '0 :
                    (sel_queue == tqps_pkg::QUEUE_LOW) ? low_rdata : high_rdata;
      routed_to  <= route;
      overflow   <= ovf;
    end
  end

  // queue pointers and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      high_head  <= '0;
      low_head   <= '0;
      high_count <= '0;
      low_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (high_wr) begin
        high_count <= high_count + CNT_W'(1);
      end
      if (low_wr) begin
        low_count <= low_count + CNT_W'(1);
      end
      if (cmd.pick && take_high) begin
        high_count <= high_count - CNT_W'(1);
        high_head  <= (high_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : high_head + PTR_W'(1);
      end
      if (cmd.pick && take_low) begin
        low_count <= low_count - CNT_W'(1);
        low_head  <= (low_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : low_head + PTR_W'(1);
      end
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.out_full = out_valid;

`ifndef NO_ASSERTIONS
  a_high_bound: assert property (@(posedge clk) disable iff (rst)
    high_count <= CNT_W'(QUEUE_DEPTH))
    else $error("high queue count beyond depth");

  a_low_bound: assert property (@(posedge clk) disable iff (rst)
    low_count <= CNT_W'(QUEUE_DEPTH))
    else $error("low queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pick && (take_high || take_low) |=> sel_valid)
    else $error("pop not reported as a valid pick");

  a_ovf_route: assert property (@(posedge clk) disable iff (rst)
    cmd.push && ovf_next |->
      (route_next == tqps_pkg::ROUTE_HIGH || route_next == tqps_pkg::ROUTE_LOW))
    else $error("overflow without a queue route");
`endif

endmodule

// File: rtl/two_queue_probabilistic_scheduler.sv
// Two-queue probabilistic scheduler. Each input transfer may return a process
// from the CPU: a preempted one is queued high when 5 * time_left <= time_limit,
// else low (dropped with overflow set if that queue is full); blocked, finished
// and invalid states are only reported. Then one id is popped: from the high
// queue when random_draw < high_share and it is non-empty, else from the low
// queue, else from the high queue, else none. Every input transfer yields
// exactly one result transfer. An item passes through accept, enqueue, pick
// with the queue memory read, and output capture; the enqueue-before-pick order
// and the registered memory read set this order. The next input is accepted once
// the controller has returned to idle after the output capture. A finished
// result waits in the output register without blocking the next input; that
// next item's capture stalls until the output register is taken.
// No clearing pass at reset.
// Depends on tqps_pkg, tqps_ctrl, tqps_datapath, tqps_ram.
module two_queue_probabilistic_scheduler #(
  parameter int QUEUE_DEPTH = tqps_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = tqps_pkg::DEF_ID_BITS,
  parameter int S_TDATA_W   = ((ID_BITS + 25 + 7) / 8) * 8,
  parameter int M_TDATA_W   = ((ID_BITS + 5 + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [tqps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tqps_pkg::CFG_W-1:0]     cfg_data,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [S_TDATA_W-1:0]           s_tdata,  // proc_id, leave_state, time_left, random_draw
  input  logic                           s_tuser,  // action
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [M_TDATA_W-1:0]           m_tdata,  // pick_id, pick_queue, routed_to, overflow
  output logic                           m_tuser   // pick_valid
);

  localparam int LEAVE_LO = ID_BITS;
  localparam int TIME_LO  = LEAVE_LO + tqps_pkg::LEAVE_W;
  localparam int DRAW_LO  = TIME_LO + tqps_pkg::TIME_W;

  tqps_pkg::cmd_t    cmd;
  tqps_pkg::status_t status;

  logic                         pick_valid, pick_queue, overflow;
  logic [ID_BITS-1:0]           pick_id;
  logic [tqps_pkg::ROUTE_W-1:0] routed_to;

  tqps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tqps_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (s_tuser),
    .proc_id     (s_tdata[ID_BITS-1:0]),
    .leave_state (s_tdata[TIME_LO-1:LEAVE_LO]),
    .time_left   (s_tdata[DRAW_LO-1:TIME_LO]),
    .random_draw (s_tdata[DRAW_LO+tqps_pkg::SHARE_W-1:DRAW_LO]),
    .m_tready    (m_tready),
    .out_valid   (m_tvalid),
    .pick_valid  (pick_valid),
    .pick_id     (pick_id),
    .pick_queue  (pick_queue),
    .routed_to   (routed_to),
    .overflow    (overflow)
  );

  assign m_tdata = M_TDATA_W'({overflow, routed_to, pick_queue, pick_id});
  assign m_tuser = pick_valid;

endmodule
